// ===== design/sas_pkg.sv =====
// shared types and codes for the sorted address set
package sas_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 11;

   typedef enum logic [0:0] {
      ACTION_INSERT = 1'b0,
      ACTION_CHECK  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      OUTCOME_ADDED   = 2'd0,
      OUTCOME_PRESENT = 2'd1,
      OUTCOME_FULL    = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_EVAL,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      action_type         action;
      logic [ADDR_W-1:0]  addr_a;
      logic [ADDR_W-1:0]  addr_b;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic               hit;
      outcome_type        insert_outcome;
   } rsp_item_type;

endpackage

// ===== design/sas_store.sv =====
// entry memory: one write port, one registered read port
module sas_store
   import sas_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [ADDR_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [ADDR_W-1:0] wr_data
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sas_engine.sv =====
// sequencer: binary search over the memory, shift-up and store, membership checks
module sas_engine
   import sas_pkg::*;
#(
   parameter int CAPACITY = 1024,
   parameter int IDX_W    = 10,
   parameter int CNT_W    = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  req_item_type      item,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_item_type      res,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   input  logic [ADDR_W-1:0] rd_data,
   output logic              wr_en,
   output logic [IDX_W-1:0]  wr_addr,
   output logic [ADDR_W-1:0] wr_data
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [ADDR_W-1:0] addr_b_ff, addr_b_in;
   action_type        action_ff, action_in;
   logic              on_b_ff, on_b_in;
   outcome_type       outcome_ff, outcome_in;
   logic              hit_ff, hit_in;

   logic [CNT_W-1:0]   mid;
   logic [CNT_W-1:0]   ptr_m1;
   logic               found;
   logic               full;
   logic [CNT_W+10:0]  count_ext;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign ptr_m1 = ptr_ff - ONE_CNT;
   assign found  = (lo_ff < count_ff) && (rd_data == key_ff);
   assign full   = (count_ff == CAP_CNT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = (lo_ff < hi_ff) ? ST_COMPARE : ST_EVAL;
         end
         ST_COMPARE: begin
            state_in = ST_SEARCH;
         end
         ST_EVAL: begin
            if (action_ff == ACTION_INSERT) begin
               state_in = (found || full) ? ST_DONE : ST_SHIFT;
            end else begin
               state_in = (found || on_b_ff) ? ST_DONE : ST_SEARCH;
            end
         end
         ST_SHIFT: begin
            if (!(ptr_ff > lo_ff)) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      ptr_in     = ptr_ff;
      wr_idx_in  = wr_idx_ff;
      wr_pend_in = wr_pend_ff;
      key_in     = key_ff;
      addr_b_in  = addr_b_ff;
      action_in  = action_ff;
      on_b_in    = on_b_ff;
      outcome_in = outcome_ff;
      hit_in     = hit_ff;
      rd_en      = 1'b0;
      rd_addr    = lo_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = wr_idx_ff;
      wr_data    = rd_data;
      item_ready = 1'b0;
      res_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               key_in     = item.addr_a;
               addr_b_in  = item.addr_b;
               action_in  = item.action;
               on_b_in    = 1'b0;
               lo_in      = '0;
               hi_in      = count_ff;
               outcome_in = OUTCOME_ADDED;
               hit_in     = 1'b0;
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en   = 1'b1;
               rd_addr = mid[IDX_W-1:0];
               mid_in  = mid;
            end else begin
               // probe the lower bound itself, when it names a held entry
               rd_en   = (lo_ff < count_ff);
               rd_addr = lo_ff[IDX_W-1:0];
            end
         end
         ST_COMPARE: begin
            if (rd_data < key_ff) begin
               lo_in = mid_ff + ONE_CNT;
            end else begin
               hi_in = mid_ff;
            end
         end
         ST_EVAL: begin
            if (action_ff == ACTION_INSERT) begin
               if (found) begin
                  outcome_in = OUTCOME_PRESENT;
               end else if (full) begin
                  outcome_in = OUTCOME_FULL;
               end else begin
                  ptr_in     = count_ff;
                  wr_pend_in = 1'b0;
               end
            end else if (found) begin
               hit_in = 1'b1;
            end else if (!on_b_ff) begin
               key_in  = addr_b_ff;
               on_b_in = 1'b1;
               lo_in   = '0;
               hi_in   = count_ff;
            end
         end
         ST_SHIFT: begin
            // read of entry i-1 overlaps the write of the entry read in the previous cycle
            wr_en = wr_pend_ff;
            if (ptr_ff > lo_ff) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_m1[IDX_W-1:0];
               wr_pend_in = 1'b1;
               wr_idx_in  = ptr_ff[IDX_W-1:0];
               ptr_in     = ptr_m1;
            end else begin
               wr_pend_in = 1'b0;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[IDX_W-1:0];
            wr_data  = key_ff;
            count_in = count_ff + ONE_CNT;
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: ;
      endcase
   end

   assign count_ext          = {11'b0, count_ff};
   assign res.entry_count    = count_ext[COUNT_W-1:0];
   assign res.hit            = hit_ff;
   assign res.insert_outcome = outcome_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      ptr_ff     <= ptr_in;
      wr_idx_ff  <= wr_idx_in;
      key_ff     <= key_in;
      addr_b_ff  <= addr_b_in;
      action_ff  <= action_in;
      on_b_ff    <= on_b_in;
      outcome_ff <= outcome_in;
      hit_ff     <= hit_in;
   end

endmodule

// ===== design/sorted_address_set_top.sv =====
// top level of the sorted address set: stream ports, result register, engine and memory
//
//   channel  direction  tdata                                    tuser
//   req      in         addr_a [31:0], addr_b [63:32]            action [0]
//   rsp      out        insert_outcome [1:0], hit [2],           -
//                       entry_count [13:3], zero [15:14]
//
// one item at a time; req_tready is high only while idle
// search per address: halving steps that read the mid entry, then a probe of the lower bound
// insert moves up the held count minus position entries, then writes the key at the position
// the memory needs no clearing after reset; the held count is reset to zero
// a stalled result sits in the rsp register while the next item is worked on
module sorted_address_set_top
   import sas_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // addr_a, addr_b
   input  logic [0:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // insert_outcome, hit, entry_count, zero pad
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   req_item_type      item;
   rsp_item_type      res;
   rsp_item_type      rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              res_valid;
   logic              res_ready;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ADDR_W-1:0] rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ADDR_W-1:0] wr_data;

   assign item.action = action_type'(req_tuser[0]);
   assign item.addr_a = req_tdata[31:0];
   assign item.addr_b = req_tdata[63:32];

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.entry_count, rsp_ff.hit, rsp_ff.insert_outcome};

   sas_engine #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   sas_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

// ===== test/testbench.sv =====
// self-checking stream testbench for the sorted address set, with a shadow copy of the set
`timescale 1ns / 1ps

module testbench;
   import sas_pkg::*;

   localparam int CAPACITY = 1024;
   localparam int HALF_PERIOD = 5;
   localparam int LONG_HOLD = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // addr_a, addr_b
   logic [0:0]  req_tuser = '0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // insert_outcome, hit, entry_count, zero pad

   sorted_address_set_top #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow copy of the set, kept in ascending order
   logic [ADDR_W-1:0] shadow_addr [CAPACITY];
   int unsigned       shadow_count = 0;
   rsp_item_type      awaited_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit saturate = 1'b0;
   int err_count = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_added = 0;
   int n_present = 0;
   int n_full = 0;
   int n_hit = 0;
   int n_miss = 0;

   typedef struct {
      action_type        action;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      bit                typed;
      outcome_type       outcome;
      logic              hit;
      int                count;
   } directed_row_type;

   // rows with typed = 0 are checked against the shadow set only
   directed_row_type directed_rows [0:20] = '{
      '{ACTION_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1, OUTCOME_ADDED,   1'b0, 1},
      '{ACTION_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, OUTCOME_PRESENT, 1'b0, 1},
      '{ACTION_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, OUTCOME_ADDED,   1'b0, 2},
      '{ACTION_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, OUTCOME_ADDED,   1'b0, 3},
      '{ACTION_INSERT, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_CHECK,  32'h0000_0000, 32'h1234_5678, 1'b1, OUTCOME_ADDED,   1'b1, 4},
      '{ACTION_CHECK,  32'h1234_5678, 32'hFFFF_FFFF, 1'b1, OUTCOME_ADDED,   1'b1, 4},
      '{ACTION_CHECK,  32'h1234_5678, 32'h8765_4321, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_CHECK,  32'h8000_0001, 32'h7FFF_FFFE, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_INSERT, 32'h8000_0001, 32'h0000_0000, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_INSERT, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_CHECK,  32'h0000_0001, 32'h0000_0001, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, OUTCOME_PRESENT, 1'b0, 7},
      '{ACTION_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, OUTCOME_PRESENT, 1'b0, 7},
      '{ACTION_CHECK,  32'hAAAA_AAAA, 32'h5555_5555, 1'b1, OUTCOME_ADDED,   1'b0, 7},
      '{ACTION_INSERT, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_INSERT, 32'h5555_5555, 32'h0000_0000, 1'b0, OUTCOME_ADDED,   1'b0, 0},
      '{ACTION_CHECK,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, OUTCOME_ADDED,   1'b0, 0}
   };

   // lower-bound search over the held part of the shadow set
   function automatic int unsigned first_not_less(logic [ADDR_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_addr[mid] < key) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   function automatic bit is_held(logic [ADDR_W-1:0] key);
      int unsigned pos;
      pos = first_not_less(key);
      return (pos < shadow_count) && (shadow_addr[pos] == key);
   endfunction

   // updates the shadow set with one item and returns the result it should cause
   function automatic rsp_item_type apply_item(req_item_type it);
      rsp_item_type r;
      int unsigned  pos;
      r.insert_outcome = OUTCOME_ADDED;
      r.hit = 1'b0;
      if (it.action == ACTION_INSERT) begin
         pos = first_not_less(it.addr_a);
         if (pos < shadow_count && shadow_addr[pos] == it.addr_a) begin
            // an address already held reports present even when the set is full
            r.insert_outcome = OUTCOME_PRESENT;
            n_present++;
         end else if (shadow_count >= CAPACITY) begin
            r.insert_outcome = OUTCOME_FULL;
            n_full++;
         end else begin
            for (int i = shadow_count; i > pos; i--) begin
               shadow_addr[i] = shadow_addr[i-1];
            end
            shadow_addr[pos] = it.addr_a;
            shadow_count++;
            n_added++;
         end
      end else begin
         r.hit = is_held(it.addr_a) || is_held(it.addr_b);
         if (r.hit) begin
            n_hit++;
         end else begin
            n_miss++;
         end
      end
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   // held address, a neighbor of one, or anything
   function automatic logic [ADDR_W-1:0] pick_addr();
      int unsigned sel;
      sel = $urandom_range(99);
      if (shadow_count == 0 || sel >= 60) begin
         return $urandom;
      end
      if (sel < 40) begin
         return shadow_addr[$urandom_range(shadow_count - 1)];
      end
      return shadow_addr[$urandom_range(shadow_count - 1)] +
             ($urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF);
   endfunction

   function automatic req_item_type make_mixed_item();
      req_item_type it;
      it.action = $urandom_range(1) ? ACTION_CHECK : ACTION_INSERT;
      it.addr_a = pick_addr();
      it.addr_b = (it.action == ACTION_CHECK) ? pick_addr() : ADDR_W'($urandom);
      return it;
   endfunction

   // keys just below the top few entries, so that few entries have to move
   function automatic req_item_type make_fill_item();
      req_item_type it;
      int unsigned  back;
      if ($urandom_range(99) < 15 || shadow_count == 0) begin
         return make_mixed_item();
      end
      back = $urandom_range(7);
      if (back > shadow_count - 1) begin
         back = shadow_count - 1;
      end
      it.action = ACTION_INSERT;
      it.addr_a = shadow_addr[shadow_count - 1 - back] - 32'd1 - $urandom_range(16'hFFFF);
      it.addr_b = $urandom;
      return it;
   endfunction

   task automatic offer_item(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.addr_b, it.addr_a};
      req_tuser  <= it.action;
      do @(posedge clock); while (!req_tready);
      predicted = apply_item(it);
      awaited_rsp.push_back(typed ? want : predicted);
      n_sent++;
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   // result checker and receiver side of the rsp channel
   int hold_left = 0;
   bit hold_used = 1'b0;

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[13:0]);
         if (awaited_rsp.size() == 0) begin
            err_count++;
            $display("%0t: unexpected transfer, expected none, got 0x%04h",
                     $time, rsp_tdata);
         end else begin
            want = awaited_rsp.pop_front();
            n_checked++;
            if (got.insert_outcome !== want.insert_outcome) begin
               report_mismatch("insert_outcome", want.insert_outcome, got.insert_outcome);
            end
            if (got.hit !== want.hit) begin
               report_mismatch("hit", want.hit, got.hit);
            end
            if (got.entry_count !== want.entry_count) begin
               report_mismatch("entry_count", want.entry_count, got.entry_count);
            end
            if (rsp_tdata[15:14] !== 2'b00) begin
               report_mismatch("pad", 0, rsp_tdata[15:14]);
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (saturate && !hold_used) begin
         // long hold-off so the block backs up and stalls its input
         hold_used = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      req_item_type     it;
      rsp_item_type     want;
      directed_row_type row;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      recv_idle_pct <= 83;
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         it.action = row.action;
         it.addr_a = row.addr_a;
         it.addr_b = row.addr_b;
         want.insert_outcome = row.outcome;
         want.hit = row.hit;
         want.entry_count = COUNT_W'(row.count);
         offer_item(it, row.typed, want);
      end
      repeat (100) offer_item(make_mixed_item(), 1'b0, want);

      send_idle_pct = 83;
      recv_idle_pct <= 32;
      repeat (100) offer_item(make_mixed_item(), 1'b0, want);

      // fill the set to capacity, then keep going against a full set
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      saturate <= 1'b1;
      while (shadow_count < CAPACITY) begin
         offer_item(make_fill_item(), 1'b0, want);
      end
      repeat (50) offer_item(make_mixed_item(), 1'b0, want);
      req_tvalid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("summary: %0d items, %0d results checked, %0d mismatches", n_sent, n_checked,
               err_count);
      $display("summary: added %0d, present %0d, full %0d, hits %0d, misses %0d, final size %0d",
               n_added, n_present, n_full, n_hit, n_miss, shadow_count);
      if (err_count == 0 && awaited_rsp.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("timeout with %0d results outstanding", awaited_rsp.size());
      $display("testbench: FAIL");
      $finish;
   end

endmodule
